// File: sv/bsc_pkg.sv
package bsc_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned CntW  = 5;

    localparam logic [1:0] REG_TEMP_COEF = 2'd0;
    localparam logic [1:0] REG_PRES_A    = 2'd1;
    localparam logic [1:0] REG_PRES_B    = 2'd2;
    localparam logic [1:0] REG_OSS       = 2'd3;

    localparam logic       KIND_TEMP = 1'b0;
    localparam logic       KIND_PRES = 1'b1;

    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] X3_OFFSET   = 32'd32768;
    localparam logic [31:0] B7_SCALE    = 32'd50000;
    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
    localparam logic [31:0] P_SQ_COEF   = 32'd3038;
    localparam logic [31:0] P_LIN_COEF  = 32'hFFFF_E343; // -7357
    localparam logic [31:0] P_OFFSET    = 32'd3791;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T_MUL,
        S_T_DIV,
        S_P_SQ,
        S_P_X1,
        S_P_X2,
        S_P_X3,
        S_P_X4,
        S_P_B4,
        S_P_B7,
        S_P_DIV,
        S_P_T,
        S_P_XC,
        S_P_XD,
        S_DONE
    } t_state;

    // launch request for a serial arithmetic unit
    typedef struct packed {
        logic        start;
        logic        sgn;
        logic [31:0] a;
        logic [31:0] b;
    } t_unit_req;

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] k);
        asr = 32'($signed(v) >>> k);
    endfunction

    // signed division by 2^k, truncating toward zero
    function automatic logic [31:0] sdiv_p2(input logic [31:0] v, input logic [4:0] k);
        logic [31:0] bias;
        bias = v[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        sdiv_p2 = asr(v + bias, k);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

// File: sv/bsc_if.sv
interface bsc_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [23:0] raw_sample;
    modport source (output valid, op, raw_sample, input ready);
    modport sink   (input valid, op, raw_sample, output ready);
endinterface

interface bsc_res_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] value;
    logic               divide_error;
    modport source (output valid, kind, value, divide_error, input ready);
    modport sink   (input valid, kind, value, divide_error, output ready);
endinterface

interface bsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/barometric_sensor_compensation.sv
// Barometric sensor compensation.
// i_req carries one raw request: op 0 is a temperature sample (raw in bits 15:0),
// op 1 a pressure sample (24 bits, shifted right by 8 minus oversampling).
// o_res returns one result per request: kind echoes op, value is temperature in
// 0.1 degC or pressure in Pa, divide_error flags a zero divisor (value then 0).
// i_cfg writes calibration registers: 0 temperature coefficients, 1 and 2
// pressure coefficients, 3 oversampling. Write only while no request is open.
// A temperature request takes one serial multiply and one serial divide, a
// pressure request ten serial multiplies and one serial divide. Each step is a
// launch, 32 one-bit iterations, then done. A zero divisor skips the rest of
// the steps. The sequencer runs the steps one after another and takes the next
// request only once the result has moved into the output register.
// A temperature request updates the stored b5 used by later pressure requests;
// a zero divisor leaves b5 unchanged. Reset clears b5 and the calibration
// registers to 0, and neither request nor configuration is taken in reset.
// The result sits in an output register; when the receiver stalls, the next
// request is still taken and computed, then held until the result slot frees.
module barometric_sensor_compensation
    import bsc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    bsc_req_if.sink   i_req,
    bsc_res_if.source o_res,
    bsc_cfg_if.sink   i_cfg
);
    t_state      r_state, n_state;
    logic        r_wait, n_wait;
    logic        r_kind;
    logic [23:0] r_raw;
    logic [63:0] r_tc, r_pa;
    logic [31:0] r_pb;
    logic [1:0]  r_oss;
    logic [31:0] r_b5;
    logic [31:0] r_x1, r_sq, r_b3, r_x3, r_b4, r_b7, r_p;
    logic [31:0] r_val;
    logic        r_err;
    logic        r_out_valid;
    logic        r_out_kind;
    logic [31:0] r_out_value;
    logic        r_out_err;

    t_unit_req   w_mreq, w_dreq;
    logic        w_mdone, w_ddone;
    logic [31:0] w_prod, w_quo;

    logic [31:0] w_b6, w_den, w_up, w_pa8, w_b5_new;
    logic        w_slot_free;

    bsc_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mreq),
        .o_done (w_mdone),
        .o_prod (w_prod)
    );

    bsc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_done (w_ddone),
        .o_quo  (w_quo)
    );

    assign w_b6        = r_b5 - B6_OFFSET;
    assign w_den       = r_x1 + sx16(r_tc[15:0]);
    assign w_up        = 32'(r_raw >> (4'd8 - {2'b00, r_oss}));
    assign w_pa8       = asr(r_p, 5'd8);
    assign w_b5_new    = r_x1 + w_quo;
    assign w_slot_free = !r_out_valid || o_res.ready;

    // configuration port: ready out of reset, writes land directly
    assign i_cfg.ready = i_rst_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc  <= '0;
            r_pa  <= '0;
            r_pb  <= '0;
            r_oss <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_TEMP_COEF: r_tc  <= i_cfg.data;
                REG_PRES_A:    r_pa  <= i_cfg.data;
                REG_PRES_B:    r_pb  <= i_cfg.data[31:0];
                REG_OSS:       r_oss <= i_cfg.data[1:0];
                default:       r_oss <= r_oss;
            endcase
        end
    end

    assign i_req.ready = i_rst_n && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    // sequencer: each arithmetic state launches its unit once and waits for done, or ends on a zero divisor
    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        w_mreq  = '{start: 1'b0, sgn: 1'b0, a: 32'd0, b: 32'd0};
        w_dreq  = '{start: 1'b0, sgn: 1'b0, a: 32'd0, b: 32'd0};
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.op == KIND_TEMP) ? S_T_MUL : S_P_SQ;
                    n_wait  = 1'b0;
                end
            end
            S_T_MUL: begin
                w_mreq.a = {16'd0, r_raw[15:0]} - {16'd0, r_tc[47:32]};
                w_mreq.b = {16'd0, r_tc[63:48]};
            end
            S_T_DIV: begin
                w_dreq.sgn = 1'b1;
                w_dreq.a   = sx16(r_tc[31:16]) << 11;
                w_dreq.b   = w_den;
            end
            S_P_SQ: begin
                w_mreq.a = w_b6;
                w_mreq.b = w_b6;
            end
            S_P_X1: begin
                w_mreq.a = sx16(r_pb[15:0]);
                w_mreq.b = r_sq;
            end
            S_P_X2: begin
                w_mreq.a = sx16(r_pa[47:32]);
                w_mreq.b = w_b6;
            end
            S_P_X3: begin
                w_mreq.a = sx16(r_pa[31:16]);
                w_mreq.b = w_b6;
            end
            S_P_X4: begin
                w_mreq.a = sx16(r_pb[31:16]);
                w_mreq.b = r_sq;
            end
            S_P_B4: begin
                w_mreq.a = {16'd0, r_pa[15:0]};
                w_mreq.b = r_x3 + X3_OFFSET;
            end
            S_P_B7: begin
                w_mreq.a = w_up - r_b3;
                w_mreq.b = B7_SCALE >> r_oss;
            end
            S_P_DIV: begin
                w_dreq.a = r_b7[31] ? r_b7 : {r_b7[30:0], 1'b0};
                w_dreq.b = r_b4;
            end
            S_P_T: begin
                w_mreq.a = w_pa8;
                w_mreq.b = w_pa8;
            end
            S_P_XC: begin
                w_mreq.a = r_x1;
                w_mreq.b = P_SQ_COEF;
            end
            S_P_XD: begin
                w_mreq.a = P_LIN_COEF;
                w_mreq.b = r_p;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // launch or finish the step of the current arithmetic state
        if (r_state != S_IDLE && r_state != S_DONE) begin
            if (!r_wait) begin
                if (r_state == S_T_DIV && w_den == 32'd0) begin
                    n_state = S_DONE;
                end else if (r_state == S_P_B7 && r_b4 == 32'd0) begin
                    n_state = S_DONE;
                end else begin
                    n_wait = 1'b1;
                    if (r_state == S_T_DIV || r_state == S_P_DIV) begin
                        w_dreq.start = 1'b1;
                    end else begin
                        w_mreq.start = 1'b1;
                    end
                end
            end else if (w_mdone || w_ddone) begin
                n_wait = 1'b0;
                unique case (r_state)
                    S_T_MUL: n_state = S_T_DIV;
                    S_P_SQ:  n_state = S_P_X1;
                    S_P_X1:  n_state = S_P_X2;
                    S_P_X2:  n_state = S_P_X3;
                    S_P_X3:  n_state = S_P_X4;
                    S_P_X4:  n_state = S_P_B4;
                    S_P_B4:  n_state = S_P_B7;
                    S_P_B7:  n_state = S_P_DIV;
                    S_P_DIV: n_state = S_P_T;
                    S_P_T:   n_state = S_P_XC;
                    S_P_XC:  n_state = S_P_XD;
                    default: n_state = S_DONE;
                endcase
            end
        end
    end

    // datapath registers: loaded when a request is taken, flagged on a zero divisor, captured when a step finishes
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_kind <= i_req.op;
            r_raw  <= i_req.raw_sample;
            r_val  <= '0;
            r_err  <= 1'b0;
        end
        if (r_state == S_T_DIV && !r_wait && w_den == 32'd0) begin
            r_err <= 1'b1;
        end
        if (r_state == S_P_B7 && !r_wait && r_b4 == 32'd0) begin
            r_err <= 1'b1;
        end
        if (r_wait && (w_mdone || w_ddone)) begin
            unique case (r_state)
                S_T_MUL: r_x1 <= sdiv_p2(w_prod, 5'd15);
                S_T_DIV: r_val <= sdiv_p2(w_b5_new + 32'd8, 5'd4);
                S_P_SQ:  r_sq <= asr(w_prod, 5'd12);
                S_P_X1:  r_x1 <= asr(w_prod, 5'd11);
                S_P_X2:  r_b3 <= asr((((r_pa[63:48] == 16'd0 ? 32'd0
                                    : sx16(r_pa[63:48]) << 2) + r_x1 + asr(w_prod, 5'd11))
                                    << r_oss) + 32'd2, 5'd2);
                S_P_X3:  r_x1 <= asr(w_prod, 5'd13);
                S_P_X4:  r_x3 <= asr(r_x1 + asr(w_prod, 5'd16) + 32'd2, 5'd2);
                S_P_B4:  r_b4 <= w_prod >> 15;
                S_P_B7:  r_b7 <= w_prod;
                S_P_DIV: r_p  <= r_b7[31] ? {w_quo[30:0], 1'b0} : w_quo;
                S_P_T:   r_x1 <= w_prod;
                S_P_XC:  r_x3 <= asr(w_prod, 5'd16);
                S_P_XD:  r_val <= r_p + sdiv_p2(r_x3 + asr(w_prod, 5'd16) + P_OFFSET, 5'd4);
                default: r_val <= r_val;
            endcase
        end
    end

    // stored b5: advance only on a temperature request with a nonzero divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b5 <= '0;
        end else if (r_state == S_T_DIV && r_wait && w_ddone) begin
            r_b5 <= w_b5_new;
        end
    end

    // output register: hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_slot_free) begin
            r_out_kind  <= r_kind;
            r_out_value <= r_err ? 32'd0 : r_val;
            r_out_err   <= r_err;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out_kind;
    assign o_res.value        = $signed(r_out_value);
    assign o_res.divide_error = r_out_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_value == 32'd0))
        else $error("divide error result with nonzero value");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("sequencer idle after accepting a request");

    a_unit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mdone || w_ddone) |-> r_wait)
        else $error("arithmetic unit finished with no step pending");

endmodule

// File: sv/bsc_mul.sv
module bsc_mul
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_unit_req   i_req,
    output logic        o_done,
    output logic [31:0] o_prod
);
    logic [31:0]     r_a, r_b, r_acc;
    logic [CntW-1:0] r_cnt;
    logic            r_busy, r_done;

    // shift-add, one multiplier bit per cycle, low 32 bits kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CntW'(DataW - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(DataW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[30:0], 1'b0};
            r_b <= {1'b0, r_b[31:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// File: sv/bsc_div.sv
module bsc_div
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_unit_req   i_req,
    output logic        o_done,
    output logic [31:0] o_quo
);
    logic [31:0]     r_quo, r_dvs;
    logic [32:0]     r_rem;
    logic [CntW-1:0] r_cnt;
    logic            r_busy, r_done, r_neg;
    logic [32:0]     w_shift, w_diff;

    // restoring division, one quotient bit per cycle on magnitudes
    assign w_shift = {r_rem[31:0], r_quo[31]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CntW'(DataW - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(DataW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= (i_req.sgn && i_req.a[31]) ? (32'd0 - i_req.a) : i_req.a;
            r_dvs <= (i_req.sgn && i_req.b[31]) ? (32'd0 - i_req.b) : i_req.b;
            r_neg <= i_req.sgn && (i_req.a[31] ^ i_req.b[31]);
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff;
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (32'd0 - r_quo) : r_quo;
endmodule

// File: sim/bsc_checker.sv
module bsc_checker
    import bsc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    bsc_req_if     req,
    bsc_res_if     res,
    bsc_cfg_if     cfg,
    output int     o_fail_count,
    output int     o_pending
);

    typedef struct {
        logic        kind;
        logic [31:0] value;
        logic        err;
    } t_comp_result;

    t_comp_result comp_q[$];

    logic [63:0] temp_coef;
    logic [63:0] pres_a;
    logic [31:0] pres_b;
    logic [1:0]  oss;
    logic [31:0] b5_held;

    function automatic logic [31:0] shr_a(input logic [31:0] v, input int n);
        logic signed [31:0] s;
        s = v;
        return s >>> n;
    endfunction

    function automatic logic [31:0] div_t(input logic [31:0] a, input logic [31:0] b);
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        sa = a;
        sb = b;
        return sa / sb;
    endfunction

    function automatic logic [31:0] ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // compensate one sample; a temperature sample with a nonzero divisor updates the held b5
    function automatic t_comp_result compensate(input logic op, input logic [23:0] raw);
        t_comp_result r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
        logic [31:0] x1, x2, x3, den, b5n, b6, sq, b3, b4, b7, p, up;
        r.kind  = op;
        r.value = 32'd0;
        r.err   = 1'b0;
        ac5 = {16'd0, temp_coef[63:48]};
        ac6 = {16'd0, temp_coef[47:32]};
        mc  = ext16(temp_coef[31:16]);
        md  = ext16(temp_coef[15:0]);
        ac1 = ext16(pres_a[63:48]);
        ac2 = ext16(pres_a[47:32]);
        ac3 = ext16(pres_a[31:16]);
        ac4 = {16'd0, pres_a[15:0]};
        b1  = ext16(pres_b[31:16]);
        b2  = ext16(pres_b[15:0]);
        if (op == KIND_TEMP) begin
            x1  = div_t(({16'd0, raw[15:0]} - ac6) * ac5, 32'd32768);
            den = x1 + md;
            if (den == 32'd0) begin
                r.err = 1'b1;
            end else begin
                b5n     = x1 + div_t(mc * 32'd2048, den);
                b5_held = b5n;
                r.value = div_t(b5n + 32'd8, 32'd16);
            end
        end else begin
            up = {8'd0, raw} >> (8 - oss);
            b6 = b5_held - 32'd4000;
            sq = shr_a(b6 * b6, 12);
            x1 = shr_a(b2 * sq, 11);
            x2 = shr_a(ac2 * b6, 11);
            b3 = shr_a(((ac1 * 32'd4 + x1 + x2) << oss) + 32'd2, 2);
            x1 = shr_a(ac3 * b6, 13);
            x2 = shr_a(b1 * sq, 16);
            x3 = shr_a(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + 32'd32768)) >> 15;
            if (b4 == 32'd0) begin
                r.err = 1'b1;
            end else begin
                b7 = (up - b3) * (32'd50000 >> oss);
                if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
                else p = (b7 / b4) * 32'd2;
                x1 = shr_a(p, 8) * shr_a(p, 8);
                x1 = shr_a(x1 * 32'd3038, 16);
                x2 = shr_a(32'hFFFF_E343 * p, 16);
                r.value = p + div_t(x1 + x2 + 32'd3791, 32'd16);
            end
        end
        return r;
    endfunction

    assign o_pending = comp_q.size();

    always @(posedge i_clk) begin
        t_comp_result got;
        t_comp_result want;
        if (!i_rst_n) begin
            temp_coef    <= 64'd0;
            pres_a       <= 64'd0;
            pres_b       <= 32'd0;
            oss          <= 2'd0;
            b5_held      = 32'd0;
            o_fail_count <= 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_TEMP_COEF: temp_coef <= cfg.data;
                    REG_PRES_A:    pres_a    <= cfg.data;
                    REG_PRES_B:    pres_b    <= cfg.data[31:0];
                    REG_OSS:       oss       <= cfg.data[1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready) comp_q.push_back(compensate(req.op, req.raw_sample));
            if (res.valid && res.ready) begin
                got.kind  = res.kind;
                got.value = res.value;
                got.err   = res.divide_error;
                if (comp_q.size() == 0) begin
                    $display("%0t: unexpected result kind=%0b value=%0d err=%0b",
                             $time, got.kind, $signed(got.value), got.err);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = comp_q.pop_front();
                    if (want.kind !== got.kind || want.value !== got.value
                        || want.err !== got.err) begin
                        $display("%0t: mismatch expected kind=%0b value=%0d err=%0b,",
                                 $time, want.kind, $signed(want.value), want.err,
                                 " got kind=%0b value=%0d err=%0b",
                                 got.kind, $signed(got.value), got.err);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: sim/tb_top.sv
module tb_top
    import bsc_pkg::*;
();

    localparam int CycleLimit = 3_000_000;
    localparam int DrainWait  = 450;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_cnt;

    // idle percentages of both sides, changed by phase
    int   tx_idle;
    int   rx_idle;
    // pulse to start a long receiver hold-off
    logic hold_go;

    bsc_req_if req ();
    bsc_res_if res ();
    bsc_cfg_if cfg ();

    barometric_sensor_compensation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_res   (res.source),
        .i_cfg   (cfg.sink)
    );

    bsc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req),
        .res          (res),
        .cfg          (cfg),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Bound the run; a hang counts as a failure.
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CycleLimit) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here.
    initial begin
        int hold_left;
        hold_left = 0;
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && hold_left == 0) hold_left = 3000;
            if (hold_left > 0) begin
                hold_left--;
                res.ready = 1'b0;
            end else begin
                res.ready = ($urandom_range(99) >= rx_idle);
            end
        end
    end

    // Offer one request; hold it until the block takes it.
    task automatic send_sample(input logic op, input logic [23:0] raw);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle) begin
            req.valid = 1'b0;
            @(negedge i_clk);
        end
        req.valid      = 1'b1;
        req.op         = op;
        req.raw_sample = raw;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    // Drain all open requests, let the sequencer settle, then write.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        req.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DrainWait) @(negedge i_clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = data;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    function automatic logic [15:0] jitter(input logic [15:0] base, input int span);
        return base + 16'($urandom_range(2 * span) - span);
    endfunction

    // Calibration set: mostly near a typical part, sometimes fully random.
    task automatic load_calibration(input bit wild);
        logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        if (wild) begin
            write_reg(REG_TEMP_COEF, {$urandom, $urandom});
            write_reg(REG_PRES_A, {$urandom, $urandom});
            write_reg(REG_PRES_B, {32'd0, $urandom});
        end else begin
            ac1 = jitter(16'd408, 300);
            ac2 = jitter(-16'sd72, 100);
            ac3 = jitter(-16'sd14383, 2000);
            ac4 = jitter(16'd32741, 3000);
            ac5 = jitter(16'd32757, 3000);
            ac6 = jitter(16'd23153, 3000);
            b1  = jitter(16'd6190, 1000);
            b2  = jitter(16'd4, 4);
            mc  = jitter(-16'sd8711, 1000);
            md  = jitter(16'd2868, 500);
            write_reg(REG_TEMP_COEF, {ac5, ac6, mc, md});
            write_reg(REG_PRES_A, {ac1, ac2, ac3, ac4});
            write_reg(REG_PRES_B, {32'd0, b1, b2});
        end
        write_reg(REG_OSS, 64'($urandom_range(3)));
    endtask

    initial begin
        int sent;
        int in_phase;
        logic [23:0] raw;
        tx_idle        = 0;
        rx_idle        = 0;
        hold_go        = 1'b0;
        req.valid      = 1'b0;
        req.op         = KIND_TEMP;
        req.raw_sample = 24'd0;
        cfg.valid      = 1'b0;
        cfg.index      = REG_TEMP_COEF;
        cfg.data       = 64'd0;
        i_rst_n        = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: all-zero calibration gives zero divisors on both paths,
        // and pressure before any temperature uses b5 of zero.
        send_sample(KIND_PRES, 24'hFFFFFF);
        send_sample(KIND_TEMP, 24'h000000);
        send_sample(KIND_TEMP, 24'hFFFFFF);

        // Typical part, extremes of the raw fields.
        write_reg(REG_TEMP_COEF, {16'd32757, 16'd23153, -16'sd8711, 16'd2868});
        write_reg(REG_PRES_A, {16'd408, -16'sd72, -16'sd14383, 16'd32741});
        write_reg(REG_PRES_B, {32'd0, 16'd6190, 16'd4});
        write_reg(REG_OSS, 64'd0);
        send_sample(KIND_PRES, 24'd6103808);
        send_sample(KIND_TEMP, 24'd27898);
        send_sample(KIND_PRES, 24'd6103808);
        send_sample(KIND_TEMP, 24'h000000);
        send_sample(KIND_PRES, 24'h000000);
        send_sample(KIND_TEMP, 24'h00FFFF);
        send_sample(KIND_PRES, 24'hFFFFFF);
        send_sample(KIND_TEMP, 24'hFF0000);

        // Oversampling at its top, then extreme coefficients.
        write_reg(REG_OSS, 64'd3);
        send_sample(KIND_TEMP, 24'd27898);
        send_sample(KIND_PRES, 24'hFFFFFF);
        send_sample(KIND_PRES, 24'h000000);
        write_reg(REG_TEMP_COEF, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRES_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRES_B, 64'h0000_0000_FFFF_FFFF);
        send_sample(KIND_TEMP, 24'hFFFFFF);
        send_sample(KIND_PRES, 24'hFFFFFF);
        write_reg(REG_TEMP_COEF, 64'h8000_0000_8000_8000);
        write_reg(REG_PRES_A, 64'h8000_8000_8000_0000);
        write_reg(REG_PRES_B, 64'h0000_0000_8000_8000);
        send_sample(KIND_TEMP, 24'h000000);
        send_sample(KIND_PRES, 24'h800000);
        // temperature divisor zero with an earlier b5 kept: ac5 and md are zero
        write_reg(REG_TEMP_COEF, {16'd0, 16'd0, 16'd100, 16'd0});
        send_sample(KIND_TEMP, 24'd1234);
        send_sample(KIND_PRES, 24'd5000000);

        // Random phases: fresh calibration, then temperatures each followed by
        // pressures; a few items are noise with any bits at all.
        sent = 0;
        while (sent < 1050) begin
            if (sent < 350) begin
                tx_idle = 28;
                rx_idle = 77;
            end else if (sent < 700) begin
                tx_idle = 77;
                rx_idle = 28;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            load_calibration($urandom_range(9) == 0);
            if (sent >= 700 && sent < 800) begin
                @(negedge i_clk);
                hold_go = 1'b1;
                repeat (2) @(negedge i_clk);
                hold_go = 1'b0;
            end
            in_phase = 0;
            while (in_phase < 70) begin
                if ($urandom_range(9) == 0) begin
                    send_sample(1'($urandom), 24'($urandom));
                end else begin
                    raw = {8'($urandom), 16'($urandom_range(32000, 24000))};
                    send_sample(KIND_TEMP, raw);
                    repeat ($urandom_range(3, 1)) begin
                        raw = 24'($urandom_range(6700000, 5200000));
                        if ($urandom_range(7) == 0) raw = 24'($urandom);
                        send_sample(KIND_PRES, raw);
                        in_phase++;
                    end
                end
                in_phase++;
            end
            sent += in_phase;
        end

        @(negedge i_clk);
        req.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DrainWait) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
